// ===== sv/emg_pkg.sv =====
// ----------------------------------------------------------------------------
// emg_pkg
// Types, codes and constants shared by the envelope generator modules.
// ----------------------------------------------------------------------------
package emg_pkg;

  localparam int LVL_W   = 27;  // signed Q2.24 level and ramp step
  localparam int DIFF_W  = 28;  // signed ramp distance
  localparam int MAG_W   = 27;  // magnitude of the ramp distance
  localparam int TICK_W  = 21;  // signed tick count
  localparam int TMAG_W  = 20;  // magnitude of a scaled delay
  localparam int VOL_W   = 17;
  localparam int FIELD_W = 16;

  localparam logic signed [LVL_W-1:0] LVL_MAX = 27'sh3FFFFFF;
  localparam logic signed [LVL_W-1:0] LVL_MIN = 27'sh4000000;
  localparam logic signed [LVL_W-1:0] ONE_Q24 = 27'sd16777216;
  localparam logic signed [LVL_W-1:0] REL_EPS = 27'sd168;
  localparam logic [TICK_W-1:0] SUSTAIN_HOLD  = 21'd128;

  localparam logic signed [FIELD_W-1:0] DLY_OFF     = 16'sd0;
  localparam logic signed [FIELD_W-1:0] DLY_HANG    = -16'sd1;
  localparam logic signed [FIELD_W-1:0] DLY_JUMP    = -16'sd2;
  localparam logic signed [FIELD_W-1:0] DLY_RESTART = -16'sd3;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_LOAD  = 2'd1,
    MODE_START = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_UPDATE_SCALE  = 2'd0,
    REG_SUSTAIN_LEVEL = 2'd1,
    REG_FADE_OUT_STEP = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    PH_OFF       = 4'd0,
    PH_INITIAL   = 4'd1,
    PH_STARTLOOP = 4'd2,
    PH_LOOP      = 4'd3,
    PH_FADE      = 4'd4,
    PH_HANG      = 4'd5,
    PH_DECAY     = 4'd6,
    PH_RELEASE   = 4'd7,
    PH_SUSTAIN   = 4'd8
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_LOADMOD,
    S_READ,
    S_DECODE,
    S_JMOD,
    S_RAMP,
    S_DIV,
    S_FADE,
    S_FIN,
    S_OUT
  } seq_state_t;

  // Saturate a widened sum to the signed 27-bit level range.
  function automatic logic signed [LVL_W-1:0] sat27(input logic signed [DIFF_W-1:0] v);
    logic signed [DIFF_W-1:0] hi;
    logic signed [DIFF_W-1:0] lo;
    hi = DIFF_W'(LVL_MAX);
    lo = DIFF_W'(LVL_MIN);
    if (v > hi) begin
      sat27 = LVL_MAX;
    end else if (v < lo) begin
      sat27 = LVL_MIN;
    end else begin
      sat27 = v[LVL_W-1:0];
    end
  endfunction

endpackage

// ===== sv/emg_point_ram.sv =====
// ----------------------------------------------------------------------------
// emg_point_ram
// Envelope point table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module emg_point_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/emg_modulo.sv =====
// ----------------------------------------------------------------------------
// emg_modulo
// Reduce a 16-bit value modulo POINTS by reciprocal multiplication.
// ----------------------------------------------------------------------------
module emg_modulo #(
  parameter int POINTS = 16,
  parameter int IW     = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [15:0]   value,
  output logic          done,
  output logic [IW-1:0] rem
);

  localparam int SH = 16 + IW;
  // reciprocal rounded up; exact for every 16-bit value
  localparam logic [17:0] RECIP =
    18'(((64'd1 << SH) + 64'(POINTS) - 64'd1) / 64'(POINTS));

  logic        busy;
  logic [15:0] val_q;
  logic [15:0] quo;
  logic [33:0] prod;
  logic [15:0] back;

  assign prod = value * RECIP;
  assign back = 16'(quo * 16'(POINTS));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= start;
      done <= busy;
    end
  end

  // take the quotient first, then subtract it back out
  always_ff @(posedge clk) begin
    if (start) begin
      val_q <= value;
      quo   <= 16'(prod >> SH);
    end
    if (busy) begin
      rem <= IW'(val_q - back);
    end
  end

endmodule

// ===== sv/emg_divider.sv =====
// ----------------------------------------------------------------------------
// emg_divider
// Signed restoring divider for the ramp step, truncating toward zero.
// ----------------------------------------------------------------------------
module emg_divider
  import emg_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [DIFF_W-1:0] dividend,
  input  logic signed [TICK_W-1:0] divisor,
  output logic                     done,
  output logic signed [DIFF_W-1:0] quotient
);

  logic              busy;
  logic [4:0]        cnt;
  logic [MAG_W-1:0]  q;
  logic [TMAG_W-1:0] r;
  logic [TMAG_W-1:0] dmag;
  logic              neg;
  logic [DIFF_W-1:0] nabs;
  logic [TICK_W-1:0] dabs;
  logic [TMAG_W:0]   r_sh;
  logic              ge;

  assign nabs = dividend[DIFF_W-1] ? DIFF_W'(-dividend) : DIFF_W'(dividend);
  assign dabs = divisor[TICK_W-1] ? TICK_W'(-divisor) : TICK_W'(divisor);
  assign r_sh = {r, q[MAG_W-1]};
  assign ge   = (r_sh >= {1'b0, dmag});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'(MAG_W);
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q    <= nabs[MAG_W-1:0];
      r    <= '0;
      dmag <= dabs[TMAG_W-1:0];
      neg  <= dividend[DIFF_W-1] ^ divisor[TICK_W-1];
    end else if (busy) begin
      r <= ge ? TMAG_W'(r_sh - {1'b0, dmag}) : r_sh[TMAG_W-1:0];
      q <= {q[MAG_W-2:0], ge};
    end
  end

  assign quotient = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});

endmodule

// ===== sv/multipoint_envelope_generator_top.sv =====
// ----------------------------------------------------------------------------
// multipoint_envelope_generator_top
// Multipoint volume envelope engine over a table of stored envelope points.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req_valid/req_stall with mode, point fields and flags.
//   A request is taken at a clock edge with req_valid high and req_stall low.
//   Load requests (mode 1) write one point; start requests (mode 2) rearm the
//   engine; tick requests (mode 0) run one update and each returns one result
//   (volume, phase) on res_valid/res_stall. Mode 3 is dropped.
//   Configuration: cfg_we writes cfg_data into register cfg_index any cycle.
// Sequencing:
//   Start and mode 3 end in S_IDLE. Load waits in S_LOADMOD for the modulo
//   unit to reduce the slot. Tick: S_EXEC, then S_OUT while off, S_FIN and
//   S_OUT for hang, decay, release or sustain, S_FADE first for fade. A
//   tick that walks the point table adds S_READ and S_DECODE per table read,
//   S_JMOD per jump (modulo unit), and S_RAMP, S_DIV (setup and the 27-step
//   divider) and S_FADE for a ramp point. The result is registered in S_OUT.
//   req_stall stays high from a taken tick or load until it is finished.
// Reset: rst clears phase (off), cursor, level, step, tick count and hang
//   flag and restores register defaults; the point table is not cleared.
// Stall: a result holds in the output register while res_stall is high; the
//   next tick finishes its work and waits for that register to free.
// ----------------------------------------------------------------------------
module multipoint_envelope_generator_top
  import emg_pkg::*;
#(
  parameter int POINTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [1:0]         mode,
  input  logic [3:0]         point_slot,
  input  logic signed [15:0] point_delay,
  input  logic signed [15:0] point_arg,
  input  logic               hang_flag,
  input  logic               decay_request,
  input  logic               release_request,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  output logic               res_valid,
  input  logic               res_stall,
  output logic [16:0]        volume,
  output logic [3:0]         phase
);

  localparam int IW = (POINTS > 1) ? $clog2(POINTS) : 1;
  localparam int HW = $clog2(POINTS + 1);

  // configuration registers
  logic [7:0]  update_scale;
  logic [23:0] sustain_level;
  logic [23:0] fade_out_step;

  // envelope state
  logic [IW-1:0]             cursor;
  phase_t                    phase_reg;
  logic signed [TICK_W-1:0]  ticks_left;
  logic signed [LVL_W-1:0]   level;
  logic signed [LVL_W-1:0]   ramp_step;
  logic                      hang_latch;
  logic [HW-1:0]             hops;

  // captured request
  logic [3:0]         slot_q;
  logic [31:0]        point_q;
  logic               decay_q;
  logic               release_q;
  logic               off_tick;

  // sequencer
  seq_state_t state;
  seq_state_t state_next;

  // point table and helpers
  logic        ram_re;
  logic [31:0] ram_rdata;
  logic        mod_start;
  logic [15:0] mod_value;
  logic        mod_done;
  logic [IW-1:0] mod_rem;
  logic        div_start;
  logic signed [DIFF_W-1:0] div_dividend;
  logic signed [TICK_W-1:0] div_divisor;
  logic        div_done;
  logic signed [DIFF_W-1:0] div_quot;

  logic signed [15:0] rd_delay;
  logic signed [15:0] rd_arg;
  logic signed [24:0] prod;
  logic [30:0]        sq;

  // ramp setup terms
  logic [24:0]              pmag;
  logic [24:0]              tmag;
  logic [24:0]              tsig;
  logic signed [TICK_W-1:0] tval;
  logic [24:0]              target;
  logic signed [DIFF_W-1:0] diff;

  // per-tick arithmetic
  logic signed [DIFF_W-1:0]  fade_sum;
  logic signed [LVL_W-1:0]   fade_lvl;
  logic signed [TICK_W-1:0]  ticks_dec;
  logic signed [LVL_W-1:0]   drop_lvl;
  logic                      take;

  assign take     = req_valid && !req_stall;
  assign rd_delay = ram_rdata[31:16];
  assign rd_arg   = ram_rdata[15:0];

  emg_point_ram #(.DEPTH(POINTS), .AW(IW)) u_ram (
    .clk   (clk),
    .we    (state == S_LOADMOD && mod_done),
    .waddr (mod_rem),
    .wdata (point_q),
    .re    (ram_re),
    .raddr (cursor),
    .rdata (ram_rdata)
  );

  emg_modulo #(.POINTS(POINTS), .IW(IW)) u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .value (mod_value),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  emg_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  // scaled delay, truncated toward zero; zero counts as one tick
  assign pmag   = prod[24] ? 25'(-prod) : 25'(prod);
  assign tmag   = pmag >> 4;
  assign tsig   = prod[24] ? 25'(-tmag) : tmag;
  assign tval   = (tsig[TICK_W-1:0] == '0) ? TICK_W'(1) : $signed(tsig[TICK_W-1:0]);
  assign target = sq[30:6];
  assign diff   = $signed({3'b000, target}) - DIFF_W'(level);

  assign fade_sum  = DIFF_W'(level) + DIFF_W'(ramp_step);
  assign fade_lvl  = sat27(fade_sum);
  assign ticks_dec = ticks_left - TICK_W'(1);
  assign drop_lvl  = sat27(DIFF_W'(level) - $signed({4'b0000, fade_out_step}));

  assign div_dividend = diff;
  assign div_divisor  = tval;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (take) begin
          priority case (mode)
            MODE_TICK: state_next = S_EXEC;
            MODE_LOAD: state_next = S_LOADMOD;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_EXEC: begin
        if (phase_reg == PH_OFF) begin
          state_next = S_OUT;
        end else begin
          unique case (phase_reg)
            PH_INITIAL:             state_next = hang_latch ? S_FIN : S_READ;
            PH_STARTLOOP, PH_LOOP:  state_next = S_READ;
            PH_FADE:                state_next = S_FADE;
            default:                state_next = S_FIN;
          endcase
        end
      end
      S_LOADMOD: if (mod_done) state_next = S_IDLE;
      S_READ:    state_next = S_DECODE;
      S_DECODE: begin
        if (rd_delay == DLY_JUMP && hops < HW'(POINTS)) begin
          state_next = S_JMOD;
        end else if (rd_delay > DLY_OFF || rd_delay < DLY_RESTART) begin
          state_next = S_RAMP;
        end else begin
          state_next = S_FIN;
        end
      end
      S_JMOD:  if (mod_done) state_next = S_READ;
      S_RAMP:  state_next = S_DIV;
      S_DIV:   if (div_done) state_next = S_FADE;
      S_FADE:  state_next = S_FIN;
      S_FIN:   state_next = S_OUT;
      S_OUT:   if (!res_valid || !res_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // strobes to the table and units
  always_comb begin
    ram_re    = (state == S_READ);
    div_start = (state == S_RAMP);
    mod_start = 1'b0;
    mod_value = {12'd0, slot_q};
    if (state == S_IDLE && take && mode == MODE_LOAD) begin
      mod_start = 1'b1;
      mod_value = {12'd0, point_slot};
    end else if (state == S_DECODE && state_next == S_JMOD) begin
      mod_start = 1'b1;
      mod_value = rd_arg;
    end
  end

  assign req_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      update_scale  <= 8'd16;
      sustain_level <= '0;
      fade_out_step <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_UPDATE_SCALE:  update_scale  <= cfg_data[7:0];
        REG_SUSTAIN_LEVEL: sustain_level <= cfg_data;
        REG_FADE_OUT_STEP: fade_out_step <= cfg_data;
        default: ;
      endcase
    end
  end

  // capture the request and the products of the point read
  always_ff @(posedge clk) begin
    if (take) begin
      slot_q    <= point_slot;
      point_q   <= {point_delay, point_arg};
      decay_q   <= decay_request;
      release_q <= release_request;
    end
    if (state == S_DECODE) begin
      prod <= rd_delay * $signed({1'b0, update_scale});
      sq   <= 31'(rd_arg * rd_arg);
    end
  end

  // envelope state update
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor     <= '0;
      phase_reg  <= PH_OFF;
      ticks_left <= '0;
      level      <= '0;
      ramp_step  <= '0;
      hang_latch <= 1'b0;
      hops       <= '0;
      off_tick   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (take && mode == MODE_START) begin
            cursor     <= '0;
            ticks_left <= '0;
            level      <= '0;
            ramp_step  <= '0;
            hang_latch <= hang_flag;
            phase_reg  <= PH_INITIAL;
          end
        end
        S_EXEC: begin
          off_tick <= (phase_reg == PH_OFF);
          hops     <= '0;
          unique case (phase_reg)
            PH_INITIAL: begin
              if (hang_latch) phase_reg <= PH_HANG;
              else cursor <= '0;
            end
            PH_STARTLOOP: cursor <= '0;
            PH_DECAY, PH_RELEASE: begin
              if (sustain_level != '0 && phase_reg == PH_DECAY) begin
                if (DIFF_W'(drop_lvl) < $signed({4'b0000, sustain_level})) begin
                  level      <= LVL_W'($signed({3'b000, sustain_level}));
                  ticks_left <= SUSTAIN_HOLD;
                  phase_reg  <= PH_SUSTAIN;
                end else begin
                  level <= drop_lvl;
                end
              end else if (drop_lvl < REL_EPS) begin
                level     <= '0;
                phase_reg <= PH_OFF;
              end else begin
                level <= drop_lvl;
              end
            end
            PH_SUSTAIN: begin
              ticks_left <= ticks_dec;
              if (ticks_dec == '0) phase_reg <= PH_RELEASE;
            end
            default: ;
          endcase
        end
        S_DECODE: begin
          // resolve control points; the ramp case goes on to setup
          if (rd_delay == DLY_OFF) begin
            phase_reg <= PH_OFF;
          end else if (rd_delay == DLY_HANG) begin
            phase_reg <= PH_HANG;
          end else if (rd_delay == DLY_RESTART) begin
            phase_reg <= PH_INITIAL;
          end else if (rd_delay == DLY_JUMP) begin
            if (hops < HW'(POINTS)) hops <= hops + HW'(1);
            else phase_reg <= PH_OFF;
          end
        end
        S_JMOD: if (mod_done) cursor <= mod_rem;
        S_RAMP: ticks_left <= tval;
        S_DIV: begin
          if (div_done) begin
            ramp_step <= sat27(div_quot);
            phase_reg <= PH_FADE;
            cursor    <= (cursor == IW'(POINTS - 1)) ? '0 : cursor + IW'(1);
          end
        end
        S_FADE: begin
          level      <= fade_lvl;
          ticks_left <= ticks_dec;
          if (ticks_dec <= 0) phase_reg <= PH_LOOP;
        end
        S_FIN: begin
          // release wins over decay
          if (release_q)    phase_reg <= PH_RELEASE;
          else if (decay_q) phase_reg <= PH_DECAY;
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == S_OUT && (!res_valid || !res_stall)) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!res_valid || !res_stall)) begin
      if (off_tick || level[LVL_W-1]) begin
        volume <= '0;
      end else if (level > ONE_Q24) begin
        volume <= 17'd65536;
      end else begin
        volume <= level[24:8];
      end
      phase <= off_tick ? PH_OFF : phase_reg;
    end
  end

endmodule

// ===== sv/emg_checker.sv =====
// ----------------------------------------------------------------------------
// emg_checker
// Port-level checks of the envelope generator, bound to the top level.
// ----------------------------------------------------------------------------
module emg_checker
  import emg_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_stall,
  input logic [1:0]  mode,
  input logic        res_valid,
  input logic        res_stall,
  input logic [16:0] volume,
  input logic [3:0]  phase
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(volume) && $stable(phase))
    else $error("stalled result changed");

  a_vol_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> volume <= 17'd65536)
    else $error("volume above unity");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> phase <= PH_SUSTAIN)
    else $error("phase code out of range");

  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && mode == MODE_TICK |=> req_stall)
    else $error("tick request not held busy");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result present after reset");

endmodule

bind multipoint_envelope_generator_top emg_checker u_emg_checker (.*);

// ===== tb/envelope_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// envelope_checker
// Watches the request, result and register ports of the envelope generator,
// tracks the envelope state on its own and compares every result returned.
// ----------------------------------------------------------------------------
module envelope_checker
  import emg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic               req_stall,
  input  logic [1:0]         mode,
  input  logic [3:0]         point_slot,
  input  logic signed [15:0] point_delay,
  input  logic signed [15:0] point_arg,
  input  logic               hang_flag,
  input  logic               decay_request,
  input  logic               release_request,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic               res_valid,
  input  logic               res_stall,
  input  logic [16:0]        volume,
  input  logic [3:0]         phase,
  output int                 errors,
  output int                 pending
);

  localparam int NPTS = 16;

  typedef struct packed {
    logic [16:0] vol;
    logic [3:0]  ph;
  } env_result_t;

  env_result_t volume_queue[$];

  logic signed [15:0] tbl_delay [NPTS];
  logic signed [15:0] tbl_arg   [NPTS];
  logic [3:0]         cursor;
  phase_t             cur_phase;
  logic signed [20:0] ticks_left;
  logic signed [26:0] level;
  logic signed [26:0] ramp_step;
  logic               hang_on;
  logic [7:0]         scale_q44;
  logic [23:0]        sustain_q24;
  logic [23:0]        fade_q24;

  function automatic logic signed [26:0] clip_level(input longint v);
    if (v > 64'sd67108863) return 27'sh3FFFFFF;
    if (v < -64'sd67108864) return 27'sh4000000;
    return v[26:0];
  endfunction

  // Walk the point table from the cursor until a point settles the phase.
  task automatic walk_points();
    int     hops;
    int     prod;
    int     t;
    longint target;
    logic signed [15:0] d;
    logic signed [15:0] a;
    hops = 0;
    forever begin
      d = tbl_delay[cursor];
      a = tbl_arg[cursor];
      if (d == DLY_OFF) begin
        cur_phase = PH_OFF;
        return;
      end
      if (d == DLY_HANG) begin
        cur_phase = PH_HANG;
        return;
      end
      if (d == DLY_RESTART) begin
        cur_phase = PH_INITIAL;
        return;
      end
      if (d == DLY_JUMP) begin
        if (hops >= NPTS) begin
          cur_phase = PH_OFF;
          return;
        end
        hops++;
        cursor = a[3:0];
        continue;
      end
      prod = int'(d) * int'(scale_q44);
      t = (prod >= 0) ? (prod >>> 4) : -((-prod) >>> 4);
      if (t == 0) t = 1;
      target = longint'((32'(int'(a) * int'(a))) >> 6);
      ticks_left = t[20:0];
      ramp_step = clip_level((target - longint'(level)) / longint'(t));
      cur_phase = PH_FADE;
      cursor = cursor + 4'd1;
      return;
    end
  endtask

  task automatic ramp_tick();
    level = clip_level(longint'(level) + longint'(ramp_step));
    ticks_left = ticks_left - 21'sd1;
    if (ticks_left <= 0) cur_phase = PH_LOOP;
  endtask

  // One tick update; returns the expected volume and phase.
  task automatic envelope_update(input logic dreq, input logic rreq,
                                 output env_result_t r);
    phase_t ph;
    longint v;
    ph = cur_phase;
    if (ph == PH_OFF) begin
      r = '0;
      return;
    end
    case (ph)
      PH_INITIAL, PH_STARTLOOP, PH_LOOP: begin
        if (ph == PH_INITIAL && hang_on) begin
          cur_phase = PH_HANG;
        end else begin
          if (ph != PH_LOOP) cursor = '0;
          walk_points();
          if (cur_phase == PH_FADE) ramp_tick();
        end
      end
      PH_FADE: ramp_tick();
      PH_DECAY, PH_RELEASE: begin
        level = clip_level(longint'(level) - longint'(fade_q24));
        if (sustain_q24 != 0 && ph == PH_DECAY) begin
          if (longint'(level) < longint'(sustain_q24)) begin
            level = $signed({3'b000, sustain_q24});
            ticks_left = 21'sd128;
            cur_phase = PH_SUSTAIN;
          end
        end else if (level < 27'sd168) begin
          level = '0;
          cur_phase = PH_OFF;
        end
      end
      PH_SUSTAIN: begin
        ticks_left = ticks_left - 21'sd1;
        if (ticks_left == 0) cur_phase = PH_RELEASE;
      end
      default: ;
    endcase
    if (dreq) cur_phase = PH_DECAY;
    if (rreq) cur_phase = PH_RELEASE;
    v = level;
    if (v < 0) v = 0;
    if (v > 64'sd16777216) v = 64'sd16777216;
    r.vol = 17'(v >> 8);
    r.ph = cur_phase;
  endtask

  always @(posedge clk) begin
    env_result_t exp_r;
    if (rst) begin
      cursor <= '0;
      cur_phase <= PH_OFF;
      ticks_left <= '0;
      level <= '0;
      ramp_step <= '0;
      hang_on <= 1'b0;
      scale_q44 <= 8'd16;
      sustain_q24 <= '0;
      fade_q24 <= '0;
      errors <= 0;
      volume_queue.delete();
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_UPDATE_SCALE:  scale_q44 = cfg_data[7:0];
          REG_SUSTAIN_LEVEL: sustain_q24 = cfg_data;
          REG_FADE_OUT_STEP: fade_q24 = cfg_data;
          default: ;
        endcase
      end
      if (req_valid && !req_stall) begin
        case (mode_t'(mode))
          MODE_LOAD: begin
            tbl_delay[point_slot] = point_delay;
            tbl_arg[point_slot] = point_arg;
          end
          MODE_START: begin
            cursor = '0;
            ticks_left = '0;
            level = '0;
            ramp_step = '0;
            hang_on = hang_flag;
            cur_phase = PH_INITIAL;
          end
          MODE_TICK: begin
            envelope_update(decay_request, release_request, exp_r);
            volume_queue.push_back(exp_r);
          end
          default: ;
        endcase
      end
      if (res_valid && !res_stall) begin
        if (volume_queue.size() == 0) begin
          $display("%0t: unexpected result volume=%0d phase=%0d", $time, volume, phase);
          errors++;
        end else begin
          exp_r = volume_queue.pop_front();
          if (volume !== exp_r.vol) begin
            $display("%0t: volume mismatch expected=%0d actual=%0d",
                     $time, exp_r.vol, volume);
            errors++;
          end
          if (phase !== exp_r.ph) begin
            $display("%0t: phase mismatch expected=%0d actual=%0d",
                     $time, exp_r.ph, phase);
            errors++;
          end
        end
      end
    end
  end

  assign pending = volume_queue.size();

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives the multipoint envelope generator with point loads, starts and tick
// requests under several register settings, with random idling on both
// channels; the envelope_checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb
  import emg_pkg::*;
;

  localparam int  RANDOM_ITEMS = 1780;
  localparam int  PHASES       = 5;
  localparam longint LIMIT     = 3000000;

  logic               clk;
  logic               rst;
  logic               req_valid;
  logic               req_stall;
  logic [1:0]         mode;
  logic [3:0]         point_slot;
  logic signed [15:0] point_delay;
  logic signed [15:0] point_arg;
  logic               hang_flag;
  logic               decay_request;
  logic               release_request;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [23:0]        cfg_data;
  logic               res_valid;
  logic               res_stall;
  logic [16:0]        volume;
  logic [3:0]         phase;

  int     errors;
  int     pending;
  longint cycles = 0;
  bit     calm;      // no idling on either side while set
  bit     hold_go;   // ask the receiver for its long hold-off
  bit     hold_done;
  int     hold_left;

  multipoint_envelope_generator_top u_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .mode(mode), .point_slot(point_slot),
    .point_delay(point_delay), .point_arg(point_arg),
    .hang_flag(hang_flag), .decay_request(decay_request),
    .release_request(release_request),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .res_valid(res_valid), .res_stall(res_stall),
    .volume(volume), .phase(phase)
  );

  envelope_checker u_checker (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .mode(mode), .point_slot(point_slot),
    .point_delay(point_delay), .point_arg(point_arg),
    .hang_flag(hang_flag), .decay_request(decay_request),
    .release_request(release_request),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .res_valid(res_valid), .res_stall(res_stall),
    .volume(volume), .phase(phase),
    .errors(errors), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side: random stalls, a calm stretch, and one long hold-off so the
  // block fills up and stalls its request input.
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      res_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      res_stall <= 1'b1;
      hold_left <= 800;
      hold_done <= 1'b1;
    end else if (calm) begin
      res_stall <= 1'b0;
    end else begin
      res_stall <= ($urandom_range(99) < 26);
    end
  end

  // Offer one request; idle first at random, hold until it is taken.
  task automatic send_request(input mode_t m, input logic [3:0] slot,
                              input logic [15:0] dly, input logic [15:0] arg,
                              input logic hang, input logic dreq, input logic rreq);
    if (!calm && $urandom_range(99) < 26) begin
      req_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 26) @(posedge clk);
    end
    mode <= m;
    point_slot <= slot;
    point_delay <= dly;
    point_arg <= arg;
    hang_flag <= hang;
    decay_request <= dreq;
    release_request <= rreq;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic load_point(input logic [3:0] slot, input logic [15:0] dly,
                            input logic [15:0] arg);
    send_request(MODE_LOAD, slot, dly, arg, $urandom_range(1), $urandom_range(1),
                 $urandom_range(1));
  endtask

  task automatic tick(input logic dreq, input logic rreq);
    send_request(MODE_TICK, 4'($urandom), 16'($urandom), 16'($urandom),
                 $urandom_range(1), dreq, rreq);
  endtask

  // Write one register, then take the write enable low again.
  task automatic write_reg(input reg_idx_t idx, input logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Drop the request, drain every result, then let a trailing load finish.
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  // Mostly ramp points, with every delay code mixed in.
  function automatic logic [15:0] random_delay();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 16'($urandom_range(1, 40));
    if (r < 60) return 16'($urandom_range(32767));
    if (r < 70) return DLY_JUMP;
    if (r < 78) return DLY_RESTART;
    if (r < 84) return DLY_HANG;
    if (r < 89) return DLY_OFF;
    return 16'(-int'($urandom_range(4, 32768)));
  endfunction

  task automatic random_request();
    int r;
    r = $urandom_range(99);
    if (r < 8) begin
      load_point(4'($urandom), random_delay(), 16'($urandom));
    end else if (r < 13) begin
      send_request(MODE_START, 4'($urandom), 16'($urandom), 16'($urandom),
                   $urandom_range(99) < 20, $urandom_range(1), $urandom_range(1));
    end else if (r < 15) begin
      send_request(MODE_NONE, 4'($urandom), 16'($urandom), 16'($urandom),
                   $urandom_range(1), $urandom_range(1), $urandom_range(1));
    end else begin
      tick($urandom_range(99) < 6, $urandom_range(99) < 6);
    end
  endtask

  initial begin
    logic [7:0]  scale_set   [PHASES];
    logic [23:0] sustain_set [PHASES];
    logic [23:0] fade_set    [PHASES];
    int n;

    scale_set   = '{8'd16, 8'd1, 8'd255, 8'($urandom_range(1, 255)), 8'd8};
    sustain_set = '{24'h400000, 24'hFFFFFF, 24'd0, 24'($urandom), 24'd0};
    fade_set    = '{24'h020000, 24'hFFFFFF, 24'h001000, 24'($urandom), 24'd0};

    calm = 1'b0;
    hold_go = 1'b0;
    rst = 1'b1;
    req_valid = 1'b0;
    mode = MODE_TICK;
    point_slot = '0;
    point_delay = '0;
    point_arg = '0;
    hang_flag = 1'b0;
    decay_request = 1'b0;
    release_request = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_UPDATE_SCALE;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(REG_UPDATE_SCALE, scale_set[0]);
    write_reg(REG_SUSTAIN_LEVEL, sustain_set[0]);
    write_reg(REG_FADE_OUT_STEP, fade_set[0]);

    // Fill the whole table first so no tick ever reads an unwritten point.
    load_point(4'd0, 16'sd1, 16'sh7FFF);            // shortest ramp to full level
    load_point(4'd1, -16'sd5, 16'sh8000);           // other negative delay
    load_point(4'd2, DLY_JUMP, -16'sd13);           // jump target reduced to slot 3
    load_point(4'd3, DLY_JUMP, 16'sd6);
    load_point(4'd4, DLY_HANG, 16'sd0);
    load_point(4'd5, DLY_RESTART, 16'sd0);
    load_point(4'd6, DLY_JUMP, 16'sd6);             // endless jumps, then off
    for (int s = 7; s < 16; s++) load_point(4'(s), DLY_OFF, 16'sh7FFF);
    load_point(4'd15, 16'sh7FFF, 16'sh8000);        // longest delay

    tick(1'b0, 1'b0);                               // tick while off
    send_request(MODE_START, 4'd0, 16'd0, 16'd0, 1'b1, 1'b0, 1'b0);
    tick(1'b0, 1'b0);                               // hang on start
    tick(1'b0, 1'b1);
    send_request(MODE_START, 4'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0);
    tick(1'b0, 1'b0);
    tick(1'b0, 1'b0);
    tick(1'b0, 1'b0);
    send_request(MODE_NONE, 4'hF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1);
    tick(1'b1, 1'b1);
    tick(1'b1, 1'b0);
    tick(1'b0, 1'b0);

    n = 0;
    for (int p = 0; p < PHASES; p++) begin
      if (p != 0) begin
        drain();
        write_reg(REG_UPDATE_SCALE, scale_set[p]);
        write_reg(REG_SUSTAIN_LEVEL, sustain_set[p]);
        write_reg(REG_FADE_OUT_STEP, fade_set[p]);
      end
      for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
        n++;
        calm <= (n >= 600 && n < 760);
        hold_go <= (n >= 300);
        random_request();
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
